>>> hdl/i2cmbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbe_pkg: shared types for the I2C master byte engine
// Command codes, request and phase word layouts, and the control and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

  // A write that ends in a stop is the longest command.
  localparam int MAX_PHASES = 22;
  localparam int IDX_W      = $clog2(MAX_PHASES);

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] tx_byte;
    logic       send_nack;
    logic [7:0] slave_byte;
    logic       slave_ack_level;
  } req_word_t;

  typedef struct packed {
    logic       scl;
    logic       sda_drive;
    logic       sda_level;
    logic [7:0] rx_data;
    logic       ack_error;
    logic       last;
  } phase_word_t;

  typedef struct packed {
    logic             load;
    logic             emit;
    logic [IDX_W-1:0] idx;
  } ctrl_t;

  typedef struct packed {
    logic last_phase;
    logic slot_free;
  } status_t;

endpackage

>>> hdl/i2cmbe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbe_ctrl: command sequencer
// Takes one request at a time and steps the phase index whenever the output
// register can take a new phase, until the datapath flags the last phase.
// ----------------------------------------------------------------------------
module i2cmbe_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  i2cmbe_pkg::status_t sts,
  output i2cmbe_pkg::ctrl_t   ctl
);
  import i2cmbe_pkg::*;

  typedef enum logic {
    IDLE,
    RUN
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] idx;

  assign req_ready = (state == IDLE);
  assign ctl.load  = req_valid && req_ready;
  assign ctl.emit  = (state == RUN) && sts.slot_free;
  assign ctl.idx   = idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      idx   <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (ctl.load) begin
            state <= RUN;
            idx   <= '0;
          end
        end
        RUN: begin
          if (ctl.emit) begin
            if (sts.last_phase) begin
              state <= IDLE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

>>> hdl/i2cmbe_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbe_dp: phase datapath
// Holds the captured request, decodes the pin levels of the current phase
// and keeps the one-word output register.
// ----------------------------------------------------------------------------
module i2cmbe_dp (
  input  logic                    clk,
  input  logic                    rst,
  input  i2cmbe_pkg::req_word_t   req,
  input  i2cmbe_pkg::ctrl_t       ctl,
  output i2cmbe_pkg::status_t     sts,
  output logic                    rsp_valid,
  input  logic                    rsp_ready,
  output i2cmbe_pkg::phase_word_t rsp
);
  import i2cmbe_pkg::*;

  localparam logic [IDX_W-1:0] BITS_END  = IDX_W'(16);
  localparam logic [IDX_W-1:0] READ_LAST = IDX_W'(19);
  localparam logic [IDX_W-1:0] STOP_LAST = IDX_W'(21);

  req_word_t   req_q;
  phase_word_t ph;
  logic        last_phase;

  always_comb begin
    ph         = '0;
    last_phase = 1'b0;
    unique case (req_q.command)
      CMD_START: begin
        case (ctl.idx)
          IDX_W'(0): {ph.scl, ph.sda_drive, ph.sda_level} = 3'b111;
          IDX_W'(1): {ph.scl, ph.sda_drive, ph.sda_level} = 3'b110;
          default:   {ph.scl, ph.sda_drive, ph.sda_level} = 3'b010;
        endcase
        last_phase = (ctl.idx == IDX_W'(2));
      end
      CMD_STOP: begin
        case (ctl.idx)
          IDX_W'(0): {ph.scl, ph.sda_drive, ph.sda_level} = 3'b010;
          IDX_W'(1): {ph.scl, ph.sda_drive, ph.sda_level} = 3'b110;
          default:   {ph.scl, ph.sda_drive, ph.sda_level} = 3'b111;
        endcase
        last_phase = (ctl.idx == IDX_W'(2));
      end
      CMD_WRITE: begin
        if (ctl.idx < BITS_END) begin
          ph.scl       = ctl.idx[0];
          ph.sda_drive = 1'b1;
          ph.sda_level = req_q.tx_byte[3'd7 - ctl.idx[3:1]];
        end else begin
          case (ctl.idx)
            IDX_W'(16): {ph.scl, ph.sda_drive, ph.sda_level} = {2'b01, req_q.tx_byte[0]};
            IDX_W'(17): {ph.scl, ph.sda_drive, ph.sda_level} = 3'b001;
            IDX_W'(18): {ph.scl, ph.sda_drive, ph.sda_level} = 3'b101;
            IDX_W'(19): begin
              if (req_q.slave_ack_level) begin
                {ph.scl, ph.sda_drive, ph.sda_level} = 3'b010;
              end else begin
                {ph.scl, ph.sda_drive, ph.sda_level} = 3'b001;
              end
            end
            IDX_W'(20): {ph.scl, ph.sda_drive, ph.sda_level} = 3'b110;
            default:    {ph.scl, ph.sda_drive, ph.sda_level} = 3'b111;
          endcase
        end
        // No ack from the slave: a stop follows and the error rides on it.
        if (req_q.slave_ack_level) begin
          last_phase   = (ctl.idx == STOP_LAST);
          ph.ack_error = last_phase;
        end else begin
          last_phase = (ctl.idx == READ_LAST);
        end
      end
      CMD_READ: begin
        if (ctl.idx < BITS_END) begin
          {ph.scl, ph.sda_drive, ph.sda_level} = {ctl.idx[0], 2'b01};
        end else if (ctl.idx == BITS_END) begin
          {ph.scl, ph.sda_drive, ph.sda_level} = 3'b001;
        end else begin
          ph.scl       = (ctl.idx == IDX_W'(18));
          ph.sda_drive = 1'b1;
          ph.sda_level = req_q.send_nack;
        end
        last_phase = (ctl.idx == READ_LAST);
        if (last_phase) begin
          ph.rx_data = req_q.slave_byte;
        end
      end
      default: last_phase = 1'b1;
    endcase
    ph.last = last_phase;
  end

  assign sts.last_phase = last_phase;
  assign sts.slot_free  = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_q <= req;
    end
    if (ctl.emit) begin
      rsp <= ph;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

>>> hdl/i2c_master_byte_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_byte_engine: I2C master pin phase sequencer
// Turns start, stop, byte write and byte read commands into the sequence of
// bus phases (SCL level, SDA drive enable, SDA level), one word per phase.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake            | Word          | Carries
//   --------+----------------------+---------------+------------------------------
//   req     | req_valid/req_ready  | req_word_t    | one command with its operands
//   rsp     | rsp_valid/rsp_ready  | phase_word_t  | one bus phase, last flags end
//
// A command is taken while the engine is idle, and then its phases leave one
// per cycle, as long as rsp does not stall, through a single output register.
// The phase counter of the controller runs to the last phase of the command:
// a start, a stop, a read, an acknowledged write, or a write the slave does
// not acknowledge, which goes on into a stop. A new command is taken as soon as the last
// phase of the previous one sits in the output register, even while that
// word still waits to be taken. A stall on rsp holds the phase counter.
// Reset clears the controller state and the output valid flag.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_ready,
  input  i2cmbe_pkg::req_word_t   req,
  output logic                    rsp_valid,
  input  logic                    rsp_ready,
  output i2cmbe_pkg::phase_word_t rsp
);
  import i2cmbe_pkg::*;

  // Of the datapath, the controller only ever sees the two status flags;
  // it drives the command bundle and takes req_valid from outside.
  ctrl_t   ctl;
  status_t sts;

  i2cmbe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  i2cmbe_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ctl       (ctl),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // Once the last phase of a command is emitted, the engine is free again.
  a_free_after_last : assert property (@(posedge clk) disable iff (rst)
    ctl.emit && sts.last_phase |=> req_ready)
    else $error("engine not free after last phase");

  // Taking a command always starts a run of phases.
  a_busy_after_load : assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> !req_ready)
    else $error("engine free right after taking a command");

  // A missing slave ack ends in the stop condition on the last phase.
  a_ack_error_stop : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.ack_error |-> rsp.last && rsp.scl && rsp.sda_drive && rsp.sda_level)
    else $error("ack error outside a stop phase");

  // Read data only appears on the last phase.
  a_rx_only_last : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.rx_data != 8'd0) |-> rsp.last)
    else $error("read data on a phase that is not the last");

endmodule
